FILE: rtl/core/swm_pkg.sv
package swm_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int SAMPLE_W   = 32;
	localparam int OUT_W      = SAMPLE_W + 1;
	localparam int WS_W       = 7;
	localparam int IDX_W      = $clog2(WINDOW_MAX);
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
	localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);

	typedef struct packed {
		logic [SAMPLE_W-1:0] val;
		logic [IDX_W-1:0]    age;
		logic                vld;
	} swm_ent_t;

	// handed from each cell to its right-hand neighbour
	typedef struct packed {
		swm_ent_t r;
		logic     le;
		logic     d;
	} swm_link_t;

	// broadcast to every cell
	typedef struct packed {
		logic                en;
		logic                kill;
		logic                clr;
		logic                full;
		logic [IDX_W-1:0]    oldest_age;
		logic [SAMPLE_W-1:0] v;
	} swm_ctl_t;

endpackage

FILE: rtl/core/swm_if.sv
interface swm_in_if import swm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       start_of_stream;

	modport source (output valid, output sample, output start_of_stream, input ready);
	modport sink   (input valid, input sample, input start_of_stream, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] median_doubled;

	modport source (output valid, output median_doubled, input ready);
	modport sink   (input valid, input median_doubled, output ready);
endinterface

FILE: rtl/core/sliding_window_median.sv
// Sliding-window median: a sorted row of WINDOW_MAX cells takes one sample per cycle
// while in_ch.ready is high; each cell compares and shifts with its neighbours.
// A result passes emit_s1 and then the swm_median output register after its sample.
// Reset (arst_n low) empties the window and sets window_size to 3; a write to
// window_size or a sample flagged start_of_stream also empties the window.
module sliding_window_median import swm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            window_size_we,
	input  logic [WS_W-1:0] window_size_wdata,
	swm_in_if.sink          in_ch,
	swm_out_if.source       out_ch
);

	logic [WS_W-1:0]     ws_q;
	logic [CNT_W-1:0]    fill_q;
	logic                emit_s1;
	logic [CNT_W-1:0]    w_act;
	logic [CNT_W-1:0]    fill_eff;
	logic [CNT_W-1:0]    fill_inc;
	logic                full;
	logic                emit_new;
	logic                acc;
	logic                adv;
	logic [IDX_W-1:0]    lo_idx;
	logic [IDX_W-1:0]    hi_idx;
	swm_ctl_t            ctl;
	swm_link_t           lnk [WINDOW_MAX+1];
	swm_ent_t            ents [WINDOW_MAX+1];
	logic [SAMPLE_W-1:0] vals [WINDOW_MAX];

	always_comb begin
		if (ws_q == '0) begin
			w_act = CNT_W'(1);
		end else if (int'(ws_q) > WINDOW_MAX) begin
			w_act = CNT_W'(WINDOW_MAX);
		end else begin
			w_act = CNT_W'(ws_q);
		end
	end

	assign acc      = in_ch.valid & in_ch.ready;
	assign fill_eff = in_ch.start_of_stream ? '0 : fill_q;
	assign fill_inc = fill_eff + CNT_W'(1);
	assign full     = fill_eff >= w_act;
	assign emit_new = full | (fill_inc == w_act);
	assign in_ch.ready = ~emit_s1 | adv;

	assign lo_idx = IDX_W'((w_act - CNT_W'(1)) >> 1);
	assign hi_idx = IDX_W'(w_act >> 1);

	assign ctl.en         = acc;
	assign ctl.kill       = in_ch.start_of_stream;
	assign ctl.clr        = window_size_we;
	assign ctl.full       = full;
	assign ctl.oldest_age = IDX_W'(w_act - CNT_W'(1));
	assign ctl.v          = in_ch.sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= WS_RESET;
			fill_q  <= '0;
			emit_s1 <= 1'b0;
		end else begin
			if (window_size_we) begin
				ws_q   <= window_size_wdata;
				fill_q <= '0;
			end else if (acc) begin
				fill_q <= full ? w_act : fill_inc;
			end
			if (in_ch.ready) begin
				emit_s1 <= acc & emit_new;
			end
		end
	end

	// cell 0 sees an empty left side: the new sample lands there unless r sorts <= it
	assign lnk[0].r  = '0;
	assign lnk[0].le = 1'b1;
	assign lnk[0].d  = 1'b0;
	assign ents[WINDOW_MAX] = '0;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		swm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.lnk_in  (lnk[i]),
			.nxt     (ents[i+1]),
			.lnk_out (lnk[i+1]),
			.ent     (ents[i])
		);
		assign vals[i] = ents[i].val;
	end

	swm_median u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.vals   (vals),
		.lo_idx (lo_idx),
		.hi_idx (hi_idx),
		.take   (emit_s1),
		.adv    (adv),
		.out_ch (out_ch)
	);

endmodule

FILE: rtl/core/swm_cell.sv
module swm_cell import swm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  swm_ctl_t  ctl,
	input  swm_link_t lnk_in,
	input  swm_ent_t  nxt,
	output swm_link_t lnk_out,
	output swm_ent_t  ent
);

	logic [SAMPLE_W-1:0] val_q;
	logic [IDX_W-1:0]    age_q;
	logic                vld_q;
	swm_ent_t            cur;
	swm_ent_t            nxt_eff;
	swm_ent_t            r;
	swm_ent_t            n;
	logic                rm;
	logic                d;
	logic                le;

	always_comb begin
		cur.val = val_q;
		cur.age = age_q;
		cur.vld = vld_q & ~ctl.kill;
		nxt_eff = nxt;
		nxt_eff.vld = nxt.vld & ~ctl.kill;
		rm = ctl.full & cur.vld & (cur.age == ctl.oldest_age);
		d  = lnk_in.d | rm;
		r  = d ? nxt_eff : cur;
		le = r.vld & ($signed(r.val) <= $signed(ctl.v));
		if (le) begin
			n = r;
			n.age = r.age + IDX_W'(1);
		end else if (lnk_in.le) begin
			n.val = ctl.v;
			n.age = '0;
			n.vld = 1'b1;
		end else begin
			n = lnk_in.r;
			n.age = lnk_in.r.age + IDX_W'(1);
		end
	end

	assign lnk_out.r  = r;
	assign lnk_out.le = le;
	assign lnk_out.d  = d;
	assign ent.val = val_q;
	assign ent.age = age_q;
	assign ent.vld = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clr) begin
			vld_q <= 1'b0;
		end else if (ctl.en) begin
			vld_q <= n.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			val_q <= n.val;
			age_q <= n.age;
		end
	end

endmodule

FILE: rtl/core/swm_median.sv
module swm_median import swm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SAMPLE_W-1:0] vals [WINDOW_MAX],
	input  logic [IDX_W-1:0]    lo_idx,
	input  logic [IDX_W-1:0]    hi_idx,
	input  logic                take,
	output logic                adv,
	swm_out_if.source           out_ch
);

	logic                    out_valid_q;
	logic signed [OUT_W-1:0] med_q;
	logic signed [OUT_W-1:0] sum;
	logic [SAMPLE_W-1:0]     lo_v;
	logic [SAMPLE_W-1:0]     hi_v;

	assign lo_v = vals[lo_idx];
	assign hi_v = vals[hi_idx];
	assign sum  = $signed({lo_v[SAMPLE_W-1], lo_v}) + $signed({hi_v[SAMPLE_W-1], hi_v});
	assign adv  = ~out_valid_q | out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			med_q <= sum;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.median_doubled = med_q;

endmodule
